### rtl/assert_macros.svh
// Assertion helpers for the top-level RTL; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/mss_pkg.sv
`default_nettype none
package mss_pkg;

  localparam int COUNT_BITS = 16;
  localparam int LIMIT_BITS = 16;
  localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

  localparam logic [7:0]  CODE_PACK   = 8'hBA;
  localparam logic [7:0]  CODE_SYSHDR = 8'hBB;
  localparam logic [7:0]  CODE_SEQHDR = 8'hB3;
  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [23:0] WINDOW_RESET = 24'hFFFFFF;

  localparam logic [LIMIT_BITS-1:0] DEFAULT_LIMIT = LIMIT_BITS'(64000);

  localparam logic [1:0] TYPE_NONE   = 2'd0;
  localparam logic [1:0] TYPE_SYSTEM = 2'd1;
  localparam logic [1:0] TYPE_VIDEO  = 2'd2;

  localparam logic [0:0] REG_SCAN_LIMIT = 1'b0;

  typedef struct packed {
    logic        size_found;
    logic [11:0] frame_height;
    logic [11:0] frame_width;
    logic [1:0]  stream_type;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage
`default_nettype wire

### rtl/mpeg_stream_type_sniffer_top.sv
// The per-byte scan is one registered step; each result is then registered in
// the output buffer. One byte is taken per cycle while s_axis_tready is high.
// A two-entry result buffer keeps s_axis_tready high while one result is stalled.
// Reset (rst, synchronous): clears the scan state, empties the result buffer and
// sets scan_limit to 64000.
`default_nettype none
`include "assert_macros.svh"
module mpeg_stream_type_sniffer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [1:0] stream_type, [13:2] frame_width,
                                           // [25:14] frame_height, [26] size_found
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [mss_pkg::LIMIT_BITS-1:0] scan_limit;
  logic                           byte_fire;
  logic                           res_valid;
  mss_pkg::result_t               res;
  mss_pkg::result_t               out_res;
  logic                           decided;
  logic                           reg_sel;

  // Register file: one register, word index in paddr[2].
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == mss_pkg::REG_SCAN_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= mss_pkg::DEFAULT_LIMIT;
    end else if (psel && penable && pwrite && reg_sel) begin
      scan_limit <= pwdata[mss_pkg::LIMIT_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32 - mss_pkg::LIMIT_BITS){1'b0}}, scan_limit} : 32'd0;

  // Scan each accepted byte; a result is produced in the same cycle and
  // registered in the output buffer.
  assign byte_fire = s_axis_tvalid && s_axis_tready;

  mss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_fire),
    .data_byte  (s_axis_tdata),
    .last_byte  (s_axis_tlast),
    .scan_limit (scan_limit),
    .res_valid  (res_valid),
    .res        (res),
    .decided    (decided)
  );

  // Hold results until the sink takes the transfer; the spare slot absorbs
  // one result while the output is stalled.
  mss_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {{(32 - mss_pkg::RESULT_BITS){1'b0}}, out_res};

  // The spare slot only fills behind a full output register.
  `ASSERT_IMPLIES(a_stall_needs_output, !s_axis_tready, m_axis_tvalid)
  // The last byte of a stream always leaves the scanner ready for a new one.
  `ASSERT_NEXT(a_last_clears, byte_fire && s_axis_tlast, !decided)
  // A result ends the scan of its stream until the last byte.
  `ASSERT_NEXT(a_result_decides, res_valid && !s_axis_tlast, decided)

endmodule
`default_nettype wire

### rtl/mss_core.sv
`default_nettype none
module mss_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           byte_valid,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,
  input  wire logic [mss_pkg::LIMIT_BITS-1:0] scan_limit,
  output logic                                res_valid,
  output mss_pkg::result_t                    res,
  output logic                                decided
);

  logic [23:0]                     window, window_next;
  logic [1:0]                      hdr_left, hdr_left_next;
  logic [15:0]                     accum, accum_next;
  logic                            system_seen, system_seen_next;
  logic                            video_seen, video_seen_next;
  logic                            other_seen, other_seen_next;
  logic [mss_pkg::COUNT_BITS-1:0]  count, count_next;
  logic                            decided_next;
  logic                            size_valid, size_valid_next;
  logic [23:0]                     size_bits, size_bits_next;
  logic [23:0]                     hdr_word;
  logic                            limit_hit;
  logic [1:0]                      dec_type;

  assign hdr_word  = {accum, data_byte};

  always_comb begin
    window_next      = window;
    hdr_left_next    = hdr_left;
    accum_next       = accum;
    system_seen_next = system_seen;
    video_seen_next  = video_seen;
    other_seen_next  = other_seen;
    count_next       = count;
    decided_next     = decided;
    size_valid_next  = size_valid;
    size_bits_next   = size_bits;
    limit_hit        = 1'b0;
    dec_type         = mss_pkg::TYPE_NONE;
    res_valid        = 1'b0;
    res.stream_type  = mss_pkg::TYPE_NONE;

    if (byte_valid && !decided) begin
      if (hdr_left != 2'd0) begin
        // sequence header byte: width then height, 12 bits each
        accum_next    = hdr_word[15:0];
        hdr_left_next = hdr_left - 2'd1;
        if (hdr_left == 2'd1) begin
          size_valid_next = 1'b1;
          size_bits_next  = hdr_word;
          if (system_seen) begin
            res_valid       = 1'b1;
            res.stream_type = mss_pkg::TYPE_SYSTEM;
            decided_next    = 1'b1;
          end
        end
      end else if (window == mss_pkg::START_PREFIX) begin
        if (data_byte == mss_pkg::CODE_PACK || data_byte == mss_pkg::CODE_SYSHDR) begin
          system_seen_next = 1'b1;
        end else if (data_byte == mss_pkg::CODE_SEQHDR) begin
          video_seen_next = 1'b1;
          other_seen_next = 1'b1;
          hdr_left_next   = 2'd3;
          accum_next      = '0;
        end else begin
          other_seen_next = 1'b1;
        end
      end
      window_next = {window[15:0], data_byte};
      if (count != '1) begin
        count_next = count + 1'b1;
      end
      // decide on the flags and count as updated by this byte
      limit_hit = mss_pkg::CMP_BITS'(count_next) >= mss_pkg::CMP_BITS'(scan_limit);
      priority if (system_seen_next) dec_type = mss_pkg::TYPE_SYSTEM;
      else if (video_seen_next)      dec_type = mss_pkg::TYPE_VIDEO;
      else if (other_seen_next)      dec_type = mss_pkg::TYPE_SYSTEM;
      else                           dec_type = mss_pkg::TYPE_NONE;
      if (!decided_next && (limit_hit || last_byte)) begin
        res_valid       = 1'b1;
        res.stream_type = dec_type;
        decided_next    = 1'b1;
      end
    end

    // size fields come from the latch as updated by this byte
    res.size_found   = size_valid_next;
    res.frame_width  = size_valid_next ? size_bits_next[23:12] : 12'd0;
    res.frame_height = size_valid_next ? size_bits_next[11:0] : 12'd0;

    if (byte_valid && last_byte) begin
      window_next      = mss_pkg::WINDOW_RESET;
      hdr_left_next    = 2'd0;
      accum_next       = '0;
      system_seen_next = 1'b0;
      video_seen_next  = 1'b0;
      other_seen_next  = 1'b0;
      count_next       = '0;
      decided_next     = 1'b0;
      size_valid_next  = 1'b0;
      size_bits_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= mss_pkg::WINDOW_RESET;
      hdr_left    <= 2'd0;
      accum       <= '0;
      system_seen <= 1'b0;
      video_seen  <= 1'b0;
      other_seen  <= 1'b0;
      count       <= '0;
      decided     <= 1'b0;
      size_valid  <= 1'b0;
      size_bits   <= '0;
    end else begin
      window      <= window_next;
      hdr_left    <= hdr_left_next;
      accum       <= accum_next;
      system_seen <= system_seen_next;
      video_seen  <= video_seen_next;
      other_seen  <= other_seen_next;
      count       <= count_next;
      decided     <= decided_next;
      size_valid  <= size_valid_next;
      size_bits   <= size_bits_next;
    end
  end

endmodule
`default_nettype wire

### rtl/mss_out_buf.sv
`default_nettype none
module mss_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  mss_pkg::result_t      in_data,
  output logic                  in_ready,
  output logic                  out_valid,
  output mss_pkg::result_t      out_data,
  input  wire logic             out_ready
);

  logic             skid_valid;
  mss_pkg::result_t skid_data;
  logic             drain;

  assign in_ready = !skid_valid;
  assign drain    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !drain) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (out_valid && !drain) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule
`default_nettype wire
